// ----- rtl/dda_lpg_pkg.sv -----
// Shared types and constants for the DDA line point generator.
`default_nettype none

package dda_lpg_pkg;

   // Coordinate width is fixed by the request and response layouts.
   localparam int COORD_BITS        = 12;
   localparam int FRAC_BITS_DEFAULT = 16;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   typedef struct packed {
      op_type                       opcode;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] point_x;
      logic signed [COORD_BITS-1:0] point_y;
      logic                         last_point;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_LOAD_X,
      ST_DIV_X,
      ST_LOAD_Y,
      ST_DIV_Y
   } seq_state_type;

   // Sequencer controls for the shared divider and the two axis datapaths.
   typedef struct packed {
      logic div_start;
      logic div_sel_y;
      logic step_wr_x;
      logic step_wr_y;
   } seq_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/dda_lpg_div.sv -----
// Shared restoring divider: |d| * 2^FRAC_BITS / steps, one quotient bit per cycle.
`default_nettype none

module dda_lpg_div
   import dda_lpg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [COORD_BITS-1:0]        dividend_mag,
   input  wire logic                         dividend_neg,
   input  wire logic [COORD_BITS-1:0]        divisor,
   output logic                              done,
   output logic signed [FRAC_BITS+1:0]       quotient
);

   localparam int NumBits   = COORD_BITS + FRAC_BITS;
   localparam int CountBits = $clog2(NumBits + 1);

   logic [NumBits-1:0]     num_ff,   num_in;
   logic [COORD_BITS-1:0]  rem_ff,   rem_in;
   logic [COORD_BITS-1:0]  dvs_ff,   dvs_in;
   logic [CountBits-1:0]   count_ff, count_in;
   logic                   busy_ff,  busy_in;
   logic                   done_ff,  done_in;
   logic                   neg_ff,   neg_in;

   logic [COORD_BITS:0]    shifted;
   logic [COORD_BITS+1:0]  trial;
   logic                   fit;
   logic [FRAC_BITS+1:0]   mag_ext;

   assign shifted = {rem_ff, num_ff[NumBits-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fit     = ~trial[COORD_BITS+1];

   always_comb begin
      num_in   = num_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      if (start) begin
         num_in   = {dividend_mag, {FRAC_BITS{1'b0}}};
         rem_in   = '0;
         dvs_in   = divisor;
         neg_in   = dividend_neg;
         count_in = CountBits'(NumBits);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         num_in   = {num_ff[NumBits-2:0], fit};
         rem_in   = fit ? trial[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
         count_in = count_ff - CountBits'(1);
         if (count_ff == CountBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   // |difference| <= steps, so the quotient never exceeds 2^FRAC_BITS.
   assign mag_ext  = {1'b0, num_ff[FRAC_BITS:0]};
   assign quotient = neg_ff ? -mag_ext : mag_ext;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ----- rtl/dda_lpg_axis.sv -----
// One axis of the DDA: fixed-point accumulator, increment and rounded point.
`default_nettype none

module dda_lpg_axis
   import dda_lpg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         load,
   input  wire logic signed [COORD_BITS-1:0] start_coord,
   input  wire logic                         step_wr,
   input  wire logic signed [FRAC_BITS+1:0]  step_val,
   input  wire logic                         advance,
   output logic [COORD_BITS-1:0]             next_point
);

   localparam int AccBits = COORD_BITS + FRAC_BITS + 1;
   localparam logic [FRAC_BITS-1:0] HalfFrac  = {1'b1, {(FRAC_BITS-1){1'b0}}};
   localparam logic [FRAC_BITS-1:0] HalfMinus = {1'b0, {(FRAC_BITS-1){1'b1}}};

   // acc = position, accp = position + half, accm = position + half - 1.
   // Rounding half away from zero is a floor of accp (positive) or accm (negative).
   logic signed [AccBits-1:0]     acc_ff,  acc_in;
   logic signed [AccBits-1:0]     accp_ff, accp_in;
   logic signed [AccBits-1:0]     accm_ff, accm_in;
   logic signed [FRAC_BITS+1:0]   step_ff, step_in;

   logic signed [AccBits-1:0]     step_ext;
   logic signed [AccBits-1:0]     sum_a, sum_p, sum_m;

   assign step_ext = {{(AccBits-FRAC_BITS-2){step_ff[FRAC_BITS+1]}}, step_ff};
   assign sum_a    = acc_ff  + step_ext;
   assign sum_p    = accp_ff + step_ext;
   assign sum_m    = accm_ff + step_ext;

   assign next_point = sum_a[AccBits-1] ? sum_m[FRAC_BITS+COORD_BITS-1:FRAC_BITS]
                                        : sum_p[FRAC_BITS+COORD_BITS-1:FRAC_BITS];

   always_comb begin
      acc_in  = acc_ff;
      accp_in = accp_ff;
      accm_in = accm_ff;
      step_in = step_wr ? step_val : step_ff;
      if (load) begin
         acc_in  = {start_coord[COORD_BITS-1], start_coord, {FRAC_BITS{1'b0}}};
         accp_in = {start_coord[COORD_BITS-1], start_coord, HalfFrac};
         accm_in = {start_coord[COORD_BITS-1], start_coord, HalfMinus};
      end else if (advance) begin
         acc_in  = sum_a;
         accp_in = sum_p;
         accm_in = sum_m;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      accp_ff <= accp_in;
      accm_ff <= accm_in;
      step_ff <= step_in;
   end

endmodule

`default_nettype wire

// ----- rtl/dda_line_point_generator_top.sv -----
// Top level of the DDA line point generator: sequencer, step counter, response register.
//
// Usage
//   Request channel (req_valid / req_stall / req_data): a start request carries both
//   endpoints; an advance request steps the current line by one pixel.
//   Response channel (rsp_valid / rsp_stall / rsp_data): one pixel per response,
//   last_point marks the final pixel of a line.
// Operation
//   Start: the first endpoint is registered and appears in the cycle after acceptance.
//   The request side then stalls while one shared restoring divider forms the x
//   increment, then the y increment, one quotient bit per cycle. A zero-length
//   line answers with last_point set and stalls nothing.
//   Advance: one pixel per cycle back to back while the response side does not
//   stall; an advance with no line in progress is taken and gives no response.
// Reset: synchronous, active high; the block comes up idle with no line drawn.
// Backpressure: the response register holds one pixel; a new request is taken while
//   it is empty or being taken, so a stalled response stalls the request side.
`default_nettype none

module dda_line_point_generator_top
   import dda_lpg_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   seq_state_type state_ff, state_in;
   seq_ctrl_type  ctrl;

   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_data_ff,  rsp_data_in;
   logic                         drawing_ff,   drawing_in;
   logic [COORD_BITS-1:0]        steps_left_ff, steps_left_in;
   logic signed [COORD_BITS:0]   dx_ff, dx_in;
   logic signed [COORD_BITS:0]   dy_ff, dy_in;
   logic [COORD_BITS-1:0]        mag_x_ff, mag_x_in;
   logic [COORD_BITS-1:0]        mag_y_ff, mag_y_in;
   logic                         neg_x_ff, neg_x_in;
   logic                         neg_y_ff, neg_y_in;
   logic [COORD_BITS-1:0]        steps_ff, steps_in;

   logic                         req_accept;
   logic                         is_start;
   logic                         is_adv;
   logic                         zero_len;
   logic signed [COORD_BITS:0]   dx_new, dy_new;
   logic [COORD_BITS:0]          abs_dx, abs_dy;
   logic [COORD_BITS-1:0]        steps_max;
   logic                         last_adv;

   logic                         div_done;
   logic signed [FRAC_BITS+1:0]  div_quot;
   logic [COORD_BITS-1:0]        px_next, py_next;

   // ---------------- handshake ----------------
   assign req_stall  = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept = req_valid && !req_stall;
   assign is_start   = req_accept && (req_data.opcode == OP_START);
   assign is_adv     = req_accept && (req_data.opcode == OP_ADVANCE) && drawing_ff;

   // ---------------- endpoint differences ----------------
   assign dx_new   = {req_data.end_x[COORD_BITS-1], req_data.end_x}
                   - {req_data.start_x[COORD_BITS-1], req_data.start_x};
   assign dy_new   = {req_data.end_y[COORD_BITS-1], req_data.end_y}
                   - {req_data.start_y[COORD_BITS-1], req_data.start_y};
   assign zero_len = (req_data.end_x == req_data.start_x)
                  && (req_data.end_y == req_data.start_y);

   // Step count is computed from the registered differences in the prep cycle.
   assign abs_dx    = dx_ff[COORD_BITS] ? -dx_ff : dx_ff;
   assign abs_dy    = dy_ff[COORD_BITS] ? -dy_ff : dy_ff;
   assign steps_max = (abs_dx > abs_dy) ? abs_dx[COORD_BITS-1:0] : abs_dy[COORD_BITS-1:0];

   assign last_adv  = (steps_left_ff == COORD_BITS'(1));

   // ---------------- sequencer ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (is_start && !zero_len) state_in = ST_PREP;
         ST_PREP:   state_in = ST_LOAD_X;
         ST_LOAD_X: state_in = ST_DIV_X;
         ST_DIV_X:  if (div_done) state_in = ST_LOAD_Y;
         ST_LOAD_Y: state_in = ST_DIV_Y;
         ST_DIV_Y:  if (div_done) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_LOAD_X: ctrl.div_start = 1'b1;
         ST_DIV_X:  ctrl.step_wr_x = div_done;
         ST_LOAD_Y: begin
            ctrl.div_start = 1'b1;
            ctrl.div_sel_y = 1'b1;
         end
         ST_DIV_Y:  ctrl.step_wr_y = div_done;
         default:   ctrl = '0;
      endcase
   end

   // ---------------- line state ----------------
   always_comb begin
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      mag_x_in      = mag_x_ff;
      mag_y_in      = mag_y_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      steps_in      = steps_ff;
      steps_left_in = steps_left_ff;
      drawing_in    = drawing_ff;
      if (is_start) begin
         dx_in      = dx_new;
         dy_in      = dy_new;
         drawing_in = !zero_len;
      end else if (is_adv) begin
         steps_left_in = steps_left_ff - COORD_BITS'(1);
         if (last_adv) drawing_in = 1'b0;
      end
      if (state_ff == ST_PREP) begin
         mag_x_in      = abs_dx[COORD_BITS-1:0];
         mag_y_in      = abs_dy[COORD_BITS-1:0];
         neg_x_in      = dx_ff[COORD_BITS];
         neg_y_in      = dy_ff[COORD_BITS];
         steps_in      = steps_max;
         steps_left_in = steps_max;
      end
   end

   // ---------------- response register ----------------
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (is_start) begin
         rsp_data_in.point_x    = req_data.start_x;
         rsp_data_in.point_y    = req_data.start_y;
         rsp_data_in.last_point = zero_len;
         rsp_valid_in           = 1'b1;
      end else if (is_adv) begin
         rsp_data_in.point_x    = px_next;
         rsp_data_in.point_y    = py_next;
         rsp_data_in.last_point = last_adv;
         rsp_valid_in           = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         drawing_ff    <= 1'b0;
         steps_left_ff <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         drawing_ff    <= drawing_in;
         steps_left_ff <= steps_left_in;
      end
      rsp_data_ff <= rsp_data_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      mag_x_ff    <= mag_x_in;
      mag_y_ff    <= mag_y_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      steps_ff    <= steps_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- shared divider ----------------
   dda_lpg_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .start        (ctrl.div_start),
      .dividend_mag (ctrl.div_sel_y ? mag_y_ff : mag_x_ff),
      .dividend_neg (ctrl.div_sel_y ? neg_y_ff : neg_x_ff),
      .divisor      (steps_ff),
      .done         (div_done),
      .quotient     (div_quot)
   );

   // ---------------- axis datapaths ----------------
   dda_lpg_axis #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_x (
      .clock       (clock),
      .load        (is_start),
      .start_coord (req_data.start_x),
      .step_wr     (ctrl.step_wr_x),
      .step_val    (div_quot),
      .advance     (is_adv),
      .next_point  (px_next)
   );

   dda_lpg_axis #(
      .FRAC_BITS (FRAC_BITS)
   ) u_axis_y (
      .clock       (clock),
      .load        (is_start),
      .start_coord (req_data.start_y),
      .step_wr     (ctrl.step_wr_y),
      .step_val    (div_quot),
      .advance     (is_adv),
      .next_point  (py_next)
   );

endmodule

`default_nettype wire
